// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/ndp_pkg.sv =====
// ----------------------------------------------------------------------------
// ndp_pkg
// Shared types and constants of the named decimal parameter parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ndp_pkg;

    localparam int ACC_W      = 32;
    localparam int NAME_W     = 48;
    localparam int NAME_BYTES = 6;
    localparam int NAME_REGS  = 4;
    localparam int PADDR_W    = 6;
    localparam int PDATA_W    = 64;
    localparam int FCNT_W     = 4;

    // register indexes
    localparam logic [2:0] REG_SLOTS_IN_USE = 3'd4;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2e;

    localparam logic [FCNT_W-1:0] FRAC_MAX = 4'd9;

    typedef enum logic [1:0] {
        MODE_NAME,
        MODE_INT,
        MODE_FRAC
    } t_mode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_MATCH,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

// ===== design/ndp_mac10.sv =====
// ----------------------------------------------------------------------------
// ndp_mac10
// Shared decimal digit unit: acc * 10 + digit, saturated to 32 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ndp_mac10
    import ndp_pkg::*;
(
    input  wire logic [ACC_W-1:0] i_acc,
    input  wire logic [3:0]       i_digit,
    output logic      [ACC_W-1:0] o_sum
);

    logic [ACC_W+3:0] w_wide;

    // x*10 = x<<3 + x<<1
    assign w_wide = {1'b0, i_acc, 3'b000} + {3'b000, i_acc, 1'b0}
                  + {{ACC_W{1'b0}}, i_digit};

    always_comb begin
        if (w_wide[ACC_W+3:ACC_W] != 4'd0) begin
            o_sum = {ACC_W{1'b1}};
        end else begin
            o_sum = w_wide[ACC_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== design/ndp_cfg.sv =====
// ----------------------------------------------------------------------------
// ndp_cfg
// APB register file: slot names and the number of slots in use.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ndp_cfg
    import ndp_pkg::*;
#(
    parameter int SLOTS = 4,
    parameter int ACT_W = $clog2(SLOTS + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output logic      [NAME_W-1:0]  o_name [SLOTS],
    output logic      [ACT_W-1:0]   o_active
);

    logic [NAME_W-1:0] r_name [SLOTS];
    logic [2:0]        r_slots_in_use;
    logic [2:0]        w_idx;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[PADDR_W-1:3];
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                r_name[s] <= '0;
            end
            r_slots_in_use <= '0;
        end else if (w_wr) begin
            for (int s = 0; s < SLOTS; s++) begin
                if (s < NAME_REGS && w_idx == 3'(s)) begin
                    r_name[s] <= pwdata[NAME_W-1:0];
                end
            end
            if (w_idx == REG_SLOTS_IN_USE) begin
                r_slots_in_use <= pwdata[2:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        for (int s = 0; s < SLOTS; s++) begin
            if (s < NAME_REGS && w_idx == 3'(s)) begin
                prdata = {{(PDATA_W-NAME_W){1'b0}}, r_name[s]};
            end
        end
        if (w_idx == REG_SLOTS_IN_USE) begin
            prdata = {{(PDATA_W-3){1'b0}}, r_slots_in_use};
        end
    end

    // a count above the slot total counts as the total
    always_comb begin
        if (int'(r_slots_in_use) > SLOTS) begin
            o_active = ACT_W'(SLOTS);
        end else begin
            o_active = ACT_W'(r_slots_in_use);
        end
    end

    assign o_name = r_name;

endmodule

`default_nettype wire

// ===== design/named_decimal_parameter_parser.sv =====
// Each item is accepted in IDLE and decoded in EXEC. A digit that does not end the message,
// or a space or dot that does not end a run, then returns to IDLE; a name character goes on
// to MATCH, one slot compared per cycle through the shared byte compare. A run end scans the
// slots in EMIT and emits results, waiting while the output is stalled, then runs MATCH for a
// new name if the ending character is a name character. Ready stays low until the item is done.
// Reset is synchronous, active low, clears config and parse state.
// ----------------------------------------------------------------------------
// named_decimal_parameter_parser
// Parses "name [space] integer [.fraction]" items and emits one result per match.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module named_decimal_parameter_parser
    import ndp_pkg::*;
#(
    parameter int SLOTS      = 4,
    parameter int NAME_CHARS = 6
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [7:0]         i_char_in,
    input  wire logic               i_end_of_message,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic      [1:0]         o_slot,
    output logic      [ACC_W-1:0]   o_integer_part,
    output logic      [ACC_W-1:0]   o_fraction_part,
    output logic      [FCNT_W-1:0]  o_fraction_digits,
    output logic                    o_last_of_run,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ACT_W  = $clog2(SLOTS + 1);
    localparam int POS_W  = $clog2(NAME_CHARS + 1);
    localparam logic [POS_W-1:0]  POS_MAX   = POS_W'(NAME_CHARS);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

    logic [NAME_W-1:0] w_name [SLOTS];
    logic [ACT_W-1:0]  w_active;

    t_state            r_state, n_state;
    t_mode             r_mode;
    logic [7:0]        r_char;
    logic              r_eom;
    logic              r_then_match;
    logic [SLOT_W-1:0] r_ptr;
    logic [POS_W-1:0]  r_pos [SLOTS];
    logic [SLOTS-1:0]  r_rej;
    logic [ACC_W-1:0]  r_int;
    logic [ACC_W-1:0]  r_frac;
    logic [FCNT_W-1:0] r_frac_cnt;

    logic              w_is_digit, w_is_space, w_is_dot;
    logic [SLOTS-1:0]  w_in_use, w_match;
    logic              w_more;
    logic [ACC_W-1:0]  w_mac_acc, w_mac_sum;
    logic [POS_W-1:0]  w_pos_cur;
    logic [7:0]        w_byte;
    logic              w_out_free, w_load, w_emit_step, w_run_clear, w_ptr_last;
    logic [SLOT_W+1:0] w_ptr_ext;

    ndp_cfg #(.SLOTS(SLOTS), .ACT_W(ACT_W)) u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_name   (w_name),
        .o_active (w_active)
    );

    assign w_mac_acc = (r_mode == MODE_FRAC) ? r_frac : r_int;

    ndp_mac10 u_mac10 (
        .i_acc   (w_mac_acc),
        .i_digit (r_char[3:0]),
        .o_sum   (w_mac_sum)
    );

    always_comb begin
        w_is_digit = r_char inside {[CH_ZERO:CH_NINE]};
        w_is_space = (r_char == CH_SPACE);
        w_is_dot   = (r_char == CH_DOT);
    end

    always_comb begin
        for (int s = 0; s < SLOTS; s++) begin
            w_in_use[s] = (ACT_W'(s) < w_active);
            w_match[s]  = w_in_use[s] && !r_rej[s] && (r_pos[s] != '0);
        end
    end

    // any match above the current slot decides the last flag
    always_comb begin
        w_more = 1'b0;
        for (int s = 0; s < SLOTS; s++) begin
            if (SLOT_W'(s) > r_ptr && w_match[s]) begin
                w_more = 1'b1;
            end
        end
    end

    // name byte at the slot's current position
    assign w_pos_cur = r_pos[r_ptr];
    always_comb begin
        w_byte = '0;
        for (int k = 0; k < NAME_BYTES; k++) begin
            if (k < NAME_CHARS && w_pos_cur == POS_W'(k)) begin
                w_byte = w_name[r_ptr][8*k +: 8];
            end
        end
    end

    assign w_out_free = !o_valid || i_ready;
    assign w_ptr_last = (r_ptr == SLOT_LAST);
    assign w_ptr_ext  = (SLOT_W + 2)'(r_ptr);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_is_digit) begin
                    n_state = r_eom ? ST_EMIT : ST_IDLE;
                end else if (r_mode == MODE_NAME) begin
                    n_state = w_is_space ? ST_IDLE : ST_MATCH;
                end else if (w_is_dot && r_mode == MODE_INT) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_MATCH: begin
                if (w_ptr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (w_run_clear) begin
                    n_state = r_then_match ? ST_MATCH : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready     = 1'b0;
        w_load      = 1'b0;
        w_emit_step = 1'b0;
        case (r_state)
            ST_IDLE: o_ready = 1'b1;
            ST_EMIT: begin
                w_load      = w_match[r_ptr] && w_out_free;
                w_emit_step = !w_match[r_ptr] || w_out_free;
            end
            default: ;
        endcase
    end

    assign w_run_clear = w_emit_step && w_ptr_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_char <= i_char_in;
            r_eom  <= i_end_of_message;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_NAME;
            r_then_match <= 1'b0;
            r_ptr        <= '0;
            r_rej        <= '0;
            r_int        <= '0;
            r_frac       <= '0;
            r_frac_cnt   <= '0;
            for (int s = 0; s < SLOTS; s++) begin
                r_pos[s] <= '0;
            end
        end else begin
            case (r_state)
                ST_EXEC: begin
                    r_ptr        <= '0;
                    r_then_match <= !w_is_digit && !w_is_space;
                    if (w_is_digit) begin
                        if (r_mode == MODE_FRAC) begin
                            if (r_frac_cnt < FRAC_MAX) begin
                                r_frac     <= w_mac_sum;
                                r_frac_cnt <= r_frac_cnt + 1'b1;
                            end
                        end else begin
                            r_int  <= w_mac_sum;
                            r_mode <= MODE_INT;
                        end
                    end else if (r_mode == MODE_NAME && w_is_space && (|w_match)) begin
                        r_mode <= MODE_INT;
                    end else if (r_mode == MODE_INT && w_is_dot) begin
                        r_mode <= MODE_FRAC;
                    end
                end
                ST_MATCH: begin
                    r_ptr <= w_ptr_last ? '0 : r_ptr + 1'b1;
                    if (w_in_use[r_ptr] && !r_rej[r_ptr]) begin
                        if (w_pos_cur < POS_MAX && w_byte == r_char) begin
                            r_pos[r_ptr] <= w_pos_cur + 1'b1;
                        end else begin
                            r_rej[r_ptr] <= 1'b1;
                        end
                    end
                end
                ST_EMIT: begin
                    if (w_emit_step) begin
                        r_ptr <= w_ptr_last ? '0 : r_ptr + 1'b1;
                    end
                    if (w_run_clear) begin
                        r_mode     <= MODE_NAME;
                        r_rej      <= '0;
                        r_int      <= '0;
                        r_frac     <= '0;
                        r_frac_cnt <= '0;
                        for (int s = 0; s < SLOTS; s++) begin
                            r_pos[s] <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_load) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_slot            <= w_ptr_ext[1:0];
            o_integer_part    <= r_int;
            o_fraction_part   <= r_frac;
            o_fraction_digits <= r_frac_cnt;
            o_last_of_run     <= !w_more;
        end
    end

    `ASSERT_IMP(a_frac_cnt_max, i_clk, i_rst_n, 1'b1, r_frac_cnt <= FRAC_MAX)
    `ASSERT_IMP(a_match_in_name_mode, i_clk, i_rst_n, r_state == ST_MATCH, r_mode == MODE_NAME)
    `ASSERT_NXT(a_run_clears, i_clk, i_rst_n, w_run_clear, r_mode == MODE_NAME && r_int == '0)
    `ASSERT_NXT(a_accept_exec, i_clk, i_rst_n, i_valid && o_ready, r_state == ST_EXEC)

endmodule

`default_nettype wire

// ===== tb/named_decimal_parameter_parser_tb.sv =====
// ----------------------------------------------------------------------------
// named_decimal_parameter_parser_tb
// Drives character streams into the parser through valid/ready and programs
// the name slots over APB. A behavioral parser in the bench predicts every
// parameter update; each update the block emits is checked against it or a table row.
// A short table of directed characters comes first, then random messages
// under three idling patterns and three slot configurations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module named_decimal_parameter_parser_tb;
    import ndp_pkg::*;

    localparam int SLOT_CNT        = 4;
    localparam int ITEMS_PER_PHASE = 90;
    localparam int QUIET_CYCLES    = 24;
    localparam int RESET_ROWS      = 2;
    localparam int DIR_N           = 32;

    localparam logic [2:0] REG_NAME_0 = 3'd0;
    localparam logic [2:0] REG_NAME_1 = 3'd1;
    localparam logic [2:0] REG_NAME_2 = 3'd2;
    localparam logic [2:0] REG_NAME_3 = 3'd3;

    typedef enum logic [1:0] {
        CHK_PRED,   // expectations come from the behavioral parser
        CHK_NONE,   // no update may follow this item
        CHK_ONE     // one typed update, zero fraction
    } t_chk;

    typedef struct packed {
        logic [7:0]  ch;
        logic        eom;
        t_chk        chk;
        logic [1:0]  slot;
        logic [31:0] ival;
    } t_dir_row;

    typedef struct packed {
        logic [7:0] ch;
        logic       eom;
    } t_char_item;

    typedef struct packed {
        logic [1:0]        slot;
        logic [ACC_W-1:0]  integer_part;
        logic [ACC_W-1:0]  fraction_part;
        logic [FCNT_W-1:0] fraction_digits;
        logic              last_of_run;
    } t_param_update;

    // slots after config: "ab", "abcdef", "x\0", six 0xFF bytes; slot count 7
    localparam t_dir_row DIR_ROWS [DIR_N] = '{
        '{8'h61,    1'b0, CHK_NONE, 2'd0, 32'd0},   // no slot in use yet
        '{8'h35,    1'b1, CHK_NONE, 2'd0, 32'd0},
        '{8'h61,    1'b0, CHK_NONE, 2'd0, 32'd0},
        '{8'h62,    1'b0, CHK_NONE, 2'd0, 32'd0},
        '{CH_SPACE, 1'b0, CHK_NONE, 2'd0, 32'd0},
        '{8'h31,    1'b0, CHK_NONE, 2'd0, 32'd0},
        '{CH_DOT,   1'b0, CHK_NONE, 2'd0, 32'd0},
        '{8'h35,    1'b1, CHK_PRED, 2'd0, 32'd0},   // two slots share the prefix
        '{8'h78,    1'b1, CHK_NONE, 2'd0, 32'd0},   // end flag on a name char
        '{8'h00,    1'b0, CHK_NONE, 2'd0, 32'd0},
        '{CH_NINE,  1'b0, CHK_NONE, 2'd0, 32'd0},   // digit right after name
        '{CH_NINE,  1'b0, CHK_NONE, 2'd0, 32'd0},
        '{CH_NINE,  1'b0, CHK_NONE, 2'd0, 32'd0},
        '{CH_NINE,  1'b0, CHK_NONE, 2'd0, 32'd0},
        '{CH_NINE,  1'b0, CHK_NONE, 2'd0, 32'd0},
        '{CH_NINE,  1'b0, CHK_NONE, 2'd0, 32'd0},
        '{CH_NINE,  1'b0, CHK_NONE, 2'd0, 32'd0},
        '{CH_NINE,  1'b0, CHK_NONE, 2'd0, 32'd0},
        '{CH_NINE,  1'b0, CHK_NONE, 2'd0, 32'd0},
        '{CH_NINE,  1'b0, CHK_NONE, 2'd0, 32'd0},   // integer saturates here
        '{CH_DOT,   1'b0, CHK_NONE, 2'd0, 32'd0},
        '{CH_DOT,   1'b0, CHK_ONE,  2'd2, 32'hFFFF_FFFF},  // second dot ends run
        '{CH_SPACE, 1'b0, CHK_NONE, 2'd0, 32'd0},   // nothing matched: ignored
        '{CH_ZERO,  1'b1, CHK_NONE, 2'd0, 32'd0},   // empty run
        '{8'hFF,    1'b0, CHK_NONE, 2'd0, 32'd0},
        '{8'hFF,    1'b0, CHK_NONE, 2'd0, 32'd0},
        '{8'hFF,    1'b0, CHK_NONE, 2'd0, 32'd0},
        '{8'hFF,    1'b0, CHK_NONE, 2'd0, 32'd0},
        '{8'hFF,    1'b0, CHK_NONE, 2'd0, 32'd0},
        '{8'hFF,    1'b0, CHK_NONE, 2'd0, 32'd0},
        '{8'hFF,    1'b0, CHK_NONE, 2'd0, 32'd0},   // seventh char: name too long
        '{8'h31,    1'b1, CHK_NONE, 2'd0, 32'd0}
    };

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                in_valid = 1'b0;
    logic [7:0]          in_char  = '0;
    logic                in_eom   = 1'b0;
    logic                out_ready = 1'b0;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [PADDR_W-1:0]  paddr    = '0;
    logic [PDATA_W-1:0]  pwdata   = '0;

    logic                o_ready;
    logic                o_valid;
    logic [1:0]          o_slot;
    logic [ACC_W-1:0]    o_integer_part;
    logic [ACC_W-1:0]    o_fraction_part;
    logic [FCNT_W-1:0]   o_fraction_digits;
    logic                o_last_of_run;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    // behavioral parser state and its copy of the registers
    logic [NAME_W-1:0]   slot_names [SLOT_CNT] = '{default: '0};
    logic [2:0]          slots_cfg = '0;
    t_mode               run_mode  = MODE_NAME;
    logic [2:0]          name_pos  [SLOT_CNT] = '{default: '0};
    logic                slot_dead [SLOT_CNT] = '{default: 1'b0};
    logic [ACC_W-1:0]    int_acc   = '0;
    logic [ACC_W-1:0]    frac_acc  = '0;
    logic [FCNT_W-1:0]   frac_cnt  = '0;

    t_param_update       fresh_updates[$];
    t_param_update       pending_updates[$];
    t_char_item          stim[$];
    t_param_update       seen, want;

    int mismatches   = 0;
    int src_idle_pct = 21;
    int snk_idle_pct = 48;

    named_decimal_parameter_parser #(
        .SLOTS      (SLOT_CNT),
        .NAME_CHARS (NAME_BYTES)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (in_valid),
        .o_ready           (o_ready),
        .i_char_in         (in_char),
        .i_end_of_message  (in_eom),
        .o_valid           (o_valid),
        .i_ready           (out_ready),
        .o_slot            (o_slot),
        .o_integer_part    (o_integer_part),
        .o_fraction_part   (o_fraction_part),
        .o_fraction_digits (o_fraction_digits),
        .o_last_of_run     (o_last_of_run),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("named_decimal_parameter_parser_tb NOT OK");
        $finish;
    end

    function automatic void log_mismatch(string what);
        mismatches++;
        if (mismatches <= 10) $display("%s", what);
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic int active_slots();
        return (slots_cfg > SLOT_CNT) ? SLOT_CNT : int'(slots_cfg);
    endfunction

    function automatic logic [ACC_W-1:0] add_digit(logic [ACC_W-1:0] acc, logic [7:0] c);
        logic [35:0] v;
        v = {4'd0, acc} * 36'd10 + 36'(c - CH_ZERO);
        return (v > 36'hFFFF_FFFF) ? '1 : v[ACC_W-1:0];
    endfunction

    // one update per surviving slot, then the parser starts over
    function automatic void close_run();
        for (int s = 0; s < active_slots(); s++) begin
            if (!slot_dead[s] && name_pos[s] != 0)
                fresh_updates.push_back(t_param_update'{2'(s), int_acc, frac_acc,
                                                        frac_cnt, 1'b0});
        end
        if (fresh_updates.size() != 0)
            fresh_updates[fresh_updates.size() - 1].last_of_run = 1'b1;
        name_pos  = '{default: '0};
        slot_dead = '{default: 1'b0};
        int_acc   = '0;
        frac_acc  = '0;
        frac_cnt  = '0;
        run_mode  = MODE_NAME;
    endfunction

    function automatic void match_name_char(logic [7:0] c);
        bit any;
        any = 1'b0;
        if (is_digit(c)) begin
            run_mode = MODE_INT;
            int_acc  = add_digit(int_acc, c);
            return;
        end
        if (c == CH_SPACE) begin
            for (int s = 0; s < active_slots(); s++)
                if (!slot_dead[s] && name_pos[s] != 0) any = 1'b1;
            if (any) run_mode = MODE_INT;
            return;
        end
        for (int s = 0; s < active_slots(); s++) begin
            if (!slot_dead[s]) begin
                if (name_pos[s] < NAME_BYTES && slot_names[s][8*name_pos[s] +: 8] == c)
                    name_pos[s]++;
                else
                    slot_dead[s] = 1'b1;
            end
        end
    endfunction

    function automatic void parse_char(logic [7:0] c, logic eom);
        fresh_updates.delete();
        if (run_mode == MODE_NAME) begin
            match_name_char(c);
            if (is_digit(c) && eom) close_run();
        end else if (is_digit(c)) begin
            if (run_mode == MODE_INT) begin
                int_acc = add_digit(int_acc, c);
            end else if (frac_cnt < FRAC_MAX) begin
                frac_acc = add_digit(frac_acc, c);
                frac_cnt++;
            end
            if (eom) close_run();
        end else if (c == CH_DOT && run_mode == MODE_INT) begin
            run_mode = MODE_FRAC;
        end else begin
            close_run();
            if (c != CH_SPACE) match_name_char(c);
        end
    endfunction

    function automatic logic [7:0] name_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (is_digit(b) || b == CH_SPACE);
        return b;
    endfunction

    // one message: name prefix, optional space, integer, optional fraction, end; or 1 to 6 random chars
    function automatic void add_run();
        int s, len, digits;
        logic [7:0] c;
        s = $urandom_range(0, SLOT_CNT - 1);
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 6))
                stim.push_back(t_char_item'{8'($urandom), 1'($urandom_range(0, 7) == 0)});
            return;
        end
        len = ($urandom_range(0, 9) == 0) ? NAME_BYTES + 1 : $urandom_range(1, NAME_BYTES);
        for (int k = 0; k < len; k++) begin
            c = (k < NAME_BYTES) ? slot_names[s][8*k +: 8] : name_byte();
            if ($urandom_range(0, 19) == 0) c = name_byte();
            stim.push_back(t_char_item'{c, 1'b0});
        end
        if ($urandom_range(0, 1)) stim.push_back(t_char_item'{CH_SPACE, 1'b0});
        digits = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 4);
        repeat (digits) stim.push_back(t_char_item'{8'(CH_ZERO + $urandom_range(0, 9)), 1'b0});
        if ($urandom_range(0, 1)) begin
            stim.push_back(t_char_item'{CH_DOT, 1'b0});
            digits = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 12)
                                                 : $urandom_range(0, 4);
            repeat (digits)
                stim.push_back(t_char_item'{8'(CH_ZERO + $urandom_range(0, 9)), 1'b0});
        end
        case ($urandom_range(0, 3))
            0: stim[stim.size() - 1].eom = 1'b1;
            1: stim.push_back(t_char_item'{CH_SPACE, 1'b0});
            2: stim.push_back(t_char_item'{name_byte(), 1'b0});
            default: ;  // next name's first char ends this run
        endcase
    endfunction

    task automatic send_char(input logic [7:0] c, input logic eom, input t_chk chk,
                             input logic [1:0] slot, input logic [31:0] ival);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_char  <= c;
        in_eom   <= eom;
        do @(posedge i_clk); while (!o_ready);
        parse_char(c, eom);
        case (chk)
            CHK_PRED: foreach (fresh_updates[k]) pending_updates.push_back(fresh_updates[k]);
            CHK_ONE:  pending_updates.push_back(t_param_update'{slot, ival, '0, '0, 1'b1});
            default:  ;
        endcase
    endtask

    // drop valid, wait for all updates, then let a pending name char finish
    task automatic settle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (pending_updates.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] mask;
        mask = (idx == REG_SLOTS_IN_USE) ? 64'h7 : 64'hFFFF_FFFF_FFFF;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(8 * idx);
        pwdata  <= value & mask;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_SLOTS_IN_USE) slots_cfg = value[2:0];
        else slot_names[idx] = value[NAME_W-1:0];
        // read back
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== (value & mask))
            log_mismatch($sformatf("register %0d readback: expected %h, got %h",
                                   idx, value & mask, prdata));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_random_names(input logic [2:0] slots);
        logic [NAME_W-1:0] nm [SLOT_CNT];
        int keep;
        for (int k = 0; k < SLOT_CNT; k++)
            for (int b = 0; b < NAME_BYTES; b++) nm[k][8*b +: 8] = name_byte();
        // shared prefixes so one run can update several slots
        for (int k = 1; k < SLOT_CNT; k++) begin
            if ($urandom_range(0, 1)) begin
                keep = $urandom_range(1, NAME_BYTES);
                for (int b = 0; b < keep; b++) nm[k][8*b +: 8] = nm[0][8*b +: 8];
            end
        end
        for (int k = 0; k < SLOT_CNT; k++) write_reg(3'(REG_NAME_0 + k), 64'(nm[k]));
        write_reg(REG_SLOTS_IN_USE, 64'(slots));
    endtask

    always @(negedge i_clk) out_ready <= ($urandom_range(0, 99) >= snk_idle_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && out_ready) begin
            seen = '{o_slot, o_integer_part, o_fraction_part, o_fraction_digits,
                     o_last_of_run};
            if (pending_updates.size() == 0) begin
                log_mismatch($sformatf("unexpected update: slot %0d int %0d frac %0d/%0d last %0d",
                                       seen.slot, seen.integer_part, seen.fraction_part,
                                       seen.fraction_digits, seen.last_of_run));
            end else begin
                want = pending_updates.pop_front();
                if (seen.slot !== want.slot || seen.integer_part !== want.integer_part ||
                    seen.fraction_part !== want.fraction_part ||
                    seen.fraction_digits !== want.fraction_digits ||
                    seen.last_of_run !== want.last_of_run)
                    log_mismatch($sformatf({"update mismatch: expected slot %0d int %0d ",
                                            "frac %0d/%0d last %0d, got slot %0d int %0d ",
                                            "frac %0d/%0d last %0d"},
                                           want.slot, want.integer_part, want.fraction_part,
                                           want.fraction_digits, want.last_of_run,
                                           seen.slot, seen.integer_part, seen.fraction_part,
                                           seen.fraction_digits, seen.last_of_run));
            end
        end
    end

    initial begin
        logic [2:0] slots;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++) begin
            if (i == RESET_ROWS) begin
                settle();
                write_reg(REG_NAME_0, 64'h0000_0000_6261);
                write_reg(REG_NAME_1, 64'h6665_6463_6261);
                write_reg(REG_NAME_2, 64'h0000_0000_0078);
                write_reg(REG_NAME_3, 64'hFFFF_FFFF_FFFF);
                write_reg(REG_SLOTS_IN_USE, 64'd7);   // above the slot count
            end
            send_char(DIR_ROWS[i].ch, DIR_ROWS[i].eom, DIR_ROWS[i].chk,
                      DIR_ROWS[i].slot, DIR_ROWS[i].ival);
        end

        for (int ph = 0; ph < 3; ph++) begin
            settle();
            case (ph)
                0: begin
                    src_idle_pct = 21;
                    snk_idle_pct = 48;
                    slots = 3'd4;
                end
                1: begin
                    src_idle_pct = 48;
                    snk_idle_pct = 21;
                    slots = 3'($urandom_range(1, 3));
                end
                default: begin
                    src_idle_pct = 0;
                    snk_idle_pct = 0;
                    slots = 3'($urandom_range(4, 7));
                end
            endcase
            load_random_names(slots);
            stim.delete();
            while (stim.size() < ITEMS_PER_PHASE) add_run();
            foreach (stim[k]) send_char(stim[k].ch, stim[k].eom, CHK_PRED, '0, '0);
        end

        settle();
        if (mismatches == 0)
            $display("named_decimal_parameter_parser_tb OK");
        else
            $display("named_decimal_parameter_parser_tb NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/ndp_pkg.sv
design/ndp_mac10.sv
design/ndp_cfg.sv
design/named_decimal_parameter_parser.sv
tb/named_decimal_parameter_parser_tb.sv
